// ===== hw/rtl/cbpid_pkg.sv =====
// Shared types, constants and helper functions of the cascaded balance controller.
`timescale 1ns / 1ps
`default_nettype none
package cbpid_pkg;

  localparam int DECIMATION_DEF = 5;
  localparam int PWM_LIMIT_DEF  = 255;

  localparam int GAIN_W    = 32;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int A_W       = 48;
  localparam int B_W       = 32;
  localparam int PROD_W    = A_W + B_W;
  localparam int RES_W     = 49;
  localparam int SUM_W     = 52;
  localparam int PWM_W     = 9;
  localparam int OP_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_KP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_KD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_KP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_KI   = 3'd7;

  localparam logic [OP_W-1:0] OP_POS_DIST  = 4'd0;
  localparam logic [OP_W-1:0] OP_POS_INT   = 4'd1;
  localparam logic [OP_W-1:0] OP_POS_P     = 4'd2;
  localparam logic [OP_W-1:0] OP_POS_I     = 4'd3;
  localparam logic [OP_W-1:0] OP_POS_D     = 4'd4;
  localparam logic [OP_W-1:0] OP_SPD_SCALE = 4'd5;
  localparam logic [OP_W-1:0] OP_SPD_INT   = 4'd6;
  localparam logic [OP_W-1:0] OP_SPD_P     = 4'd7;
  localparam logic [OP_W-1:0] OP_SPD_I     = 4'd8;
  localparam logic [OP_W-1:0] OP_ANG_P     = 4'd9;
  localparam logic [OP_W-1:0] OP_ANG_D     = 4'd10;
  localparam logic [OP_W-1:0] OP_ROT_DIFF  = 4'd11;
  localparam logic [OP_W-1:0] OP_ROT_INT   = 4'd12;
  localparam logic [OP_W-1:0] OP_ROT_P     = 4'd13;
  localparam logic [OP_W-1:0] OP_ROT_I     = 4'd14;

  localparam logic signed [B_W-1:0] K_DIST_PER_PULSE = 32'sd5397215;
  localparam logic signed [B_W-1:0] K_DEG_PER_PULSE  = 32'sd17479;
  localparam logic signed [B_W-1:0] K_DT5            = 32'sd3277;
  localparam logic signed [B_W-1:0] K_DT             = 32'sd655;
  localparam logic signed [B_W-1:0] K_POS_KI         = 32'sd655;
  localparam logic signed [B_W-1:0] K_SPEED_SCALE    = 32'sd796;

  localparam logic signed [SUM_W-1:0] LIM_PROD  = SUM_W'(48'h7FFF_FFFF_FFFF);
  localparam logic signed [SUM_W-1:0] LIM_POS   = SUM_W'(32768);
  localparam logic signed [SUM_W-1:0] LIM_SPD   = SUM_W'(1179648);
  localparam logic signed [SUM_W-1:0] ONE_Q16   = SUM_W'(65536);
  localparam logic signed [SUM_W-1:0] S32_MAX   = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0] S32_MIN   = -S32_MAX - SUM_W'(1);
  localparam logic signed [15:0]      TILT_LIM  = 16'sd10240;

  typedef struct packed {
    logic            load;
    logic            start;
    logic            wb;
    logic            out_load;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
  } sts_t;

  function automatic logic signed [GAIN_W-1:0] gain_reset(input logic [CFG_IDX_W-1:0] idx);
    logic signed [GAIN_W-1:0] v;
    unique case (idx)
      REG_ANGLE_KP:    v = 32'sd2621440;
      REG_ANGLE_KD:    v = -32'sd393216;
      REG_POSITION_KP: v = 32'sd1311;
      REG_POSITION_KD: v = 32'sd328;
      REG_SPEED_KP:    v = 32'sd52429;
      REG_SPEED_KI:    v = 32'sd32768;
      REG_ROTATE_KP:   v = 32'sd1310720;
      REG_ROTATE_KI:   v = 32'sd983040;
      default:         v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [SUM_W-1:0] clamp_s(input logic signed [SUM_W-1:0] x,
                                                      input logic signed [SUM_W-1:0] lim);
    logic signed [SUM_W-1:0] r;
    if (x > lim) r = lim;
    else if (x < -lim) r = -lim;
    else r = x;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] r;
    if (x > S32_MAX) r = S32_MAX;
    else if (x < S32_MIN) r = S32_MIN;
    else r = x;
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cbpid_ifs.sv =====
// Request channel interfaces for control ticks and motor drive results.
`timescale 1ns / 1ps
`default_nettype none
interface cbpid_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic signed [15:0] tilt;
  logic signed [15:0] tilt_rate;
  logic signed [31:0] position_goal;
  logic signed [31:0] heading_goal;
  modport source (output valid, left_count, right_count, tilt, tilt_rate, position_goal,
                  heading_goal, input ready);
  modport sink (input valid, left_count, right_count, tilt, tilt_rate, position_goal,
                heading_goal, output ready);
endinterface

interface cbpid_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] pwm_left;
  logic signed [8:0] pwm_right;
  logic              drive_enable;
  modport source (output valid, pwm_left, pwm_right, drive_enable, input ready);
  modport sink (input valid, pwm_left, pwm_right, drive_enable, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cbpid_mul.sv =====
// Sequential Q16.16 multiplier; non-raw: rounds toward zero, saturates.
`timescale 1ns / 1ps
`default_nettype none
module cbpid_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              raw,
  input  logic signed [cbpid_pkg::A_W-1:0]  a,
  input  logic signed [cbpid_pkg::B_W-1:0]  b,
  output logic                              done,
  output logic signed [cbpid_pkg::RES_W-1:0] res
);
  import cbpid_pkg::*;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_LO   = 2'd1;
  localparam logic [1:0] M_HI   = 2'd2;
  localparam logic [1:0] M_FIN  = 2'd3;
  localparam int HALF = A_W / 2;

  logic [1:0]        step;
  logic [A_W-1:0]    ma;
  logic [B_W-1:0]    mb;
  logic              neg;
  logic              raw_r;
  logic [PROD_W-1:0] acc;
  logic [HALF-1:0]   ma_sel;
  logic [HALF+B_W-1:0] pp;
  logic [PROD_W-17:0] qmag;
  logic [A_W-1:0]    mag;

  assign ma_sel = (step == M_LO) ? ma[HALF-1:0] : ma[A_W-1:HALF];
  assign pp     = ma_sel * mb;
  assign qmag   = acc[PROD_W-1:16];

  always_comb begin
    if (raw_r) mag = acc[A_W-1:0];
    else if (qmag > (PROD_W-16)'(LIM_PROD)) mag = LIM_PROD[A_W-1:0];
    else mag = qmag[A_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= M_IDLE;
      done <= 1'b0;
    end else begin
      done <= (step == M_FIN);
      unique case (step)
        M_IDLE:  step <= start ? M_LO : M_IDLE;
        M_LO:    step <= M_HI;
        M_HI:    step <= M_FIN;
        M_FIN:   step <= M_IDLE;
        default: step <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma    <= a[A_W-1] ? A_W'(-a) : A_W'(a);
      mb    <= b[B_W-1] ? B_W'(-b) : B_W'(b);
      neg   <= a[A_W-1] ^ b[B_W-1];
      raw_r <= raw;
    end
    if (step == M_LO) acc <= PROD_W'(pp);
    if (step == M_HI) acc <= acc + (PROD_W'(pp) << HALF);
    if (step == M_FIN) res <= neg ? -RES_W'(mag) : RES_W'(mag);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cbpid_datapath.sv =====
// Datapath: gain registers, loop state, operand selection, write-back and PWM output.
`timescale 1ns / 1ps
`default_nettype none
module cbpid_datapath #(
  parameter int PWM_LIMIT = cbpid_pkg::PWM_LIMIT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cbpid_pkg::cmd_t                       cmd,
  output cbpid_pkg::sts_t                       sts,
  input  logic                                  cfg_we,
  input  logic [cbpid_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbpid_pkg::GAIN_W-1:0]          cfg_data,
  input  logic signed [31:0]                    left_count,
  input  logic signed [31:0]                    right_count,
  input  logic signed [15:0]                    tilt,
  input  logic signed [15:0]                    tilt_rate,
  input  logic signed [31:0]                    position_goal,
  input  logic signed [31:0]                    heading_goal,
  output logic signed [cbpid_pkg::PWM_W-1:0]    pwm_left,
  output logic signed [cbpid_pkg::PWM_W-1:0]    pwm_right,
  output logic                                  drive_enable
);
  import cbpid_pkg::*;

  localparam logic signed [SUM_W-1:0] PWM_Q  = SUM_W'(PWM_LIMIT) <<< 16;
  localparam logic signed [SUM_W-1:0] PWM_HI = SUM_W'(PWM_LIMIT - 10);

  logic signed [GAIN_W-1:0] gain [NUM_REGS];
  logic signed [31:0] left_r, right_r, pgoal_r, hgoal_r;
  logic signed [15:0] tilt_r, rate_r;
  logic signed [31:0] err, pos_eprev, mprev, pos_hold, spd_hold;
  logic signed [A_W-1:0] pint, sint, rint;
  logic signed [SUM_W-1:0] sum, ang_sum, rot_sum;

  logic signed [32:0] sum_lr, mean33, diff_lr;
  logic signed [31:0] mean;
  logic signed [A_W-1:0] dd, d20;
  logic signed [31:0] ang_err;
  logic signed [A_W-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic mul_raw;
  logic mul_done;
  logic signed [RES_W-1:0] res;
  logic signed [SUM_W-1:0] rx;

  function automatic logic [PWM_W-1:0] to_pwm(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] mag;
    logic signed [SUM_W-1:0] r;
    mag = (v < 0) ? -v : v;
    mag = mag >>> 16;
    r = (v < 0) ? -mag : mag;
    if (v > PWM_Q) r = PWM_HI;
    else if (v < -PWM_Q) r = -PWM_HI;
    return r[PWM_W-1:0];
  endfunction

  assign sum_lr  = {left_r[31], left_r} + {right_r[31], right_r};
  assign mean33  = (sum_lr + 33'(sum_lr[32])) >>> 1;
  assign mean    = mean33[31:0];
  assign diff_lr = {left_r[31], left_r} - {right_r[31], right_r};
  assign dd      = A_W'(err) - A_W'(pos_eprev);
  assign d20     = (dd <<< 4) + (dd <<< 2);
  assign ang_err = sat32(SUM_W'(spd_hold) - (SUM_W'(tilt_r) <<< 8) + ONE_Q16);
  assign rx      = SUM_W'(res);
  assign sts.mul_done = mul_done;

  always_comb begin
    mul_raw = 1'b0;
    unique case (cmd.op)
      OP_POS_DIST:  begin mul_a = A_W'(mean);      mul_b = K_DIST_PER_PULSE;       end
      OP_POS_INT:   begin mul_a = A_W'(err);       mul_b = K_DT5;                  end
      OP_POS_P:     begin mul_a = A_W'(err);       mul_b = gain[REG_POSITION_KP];  end
      OP_POS_I:     begin mul_a = pint;            mul_b = K_POS_KI;               end
      OP_POS_D:     begin mul_a = d20;             mul_b = gain[REG_POSITION_KD];  end
      OP_SPD_SCALE: begin
        mul_a = A_W'(pos_hold); mul_b = K_SPEED_SCALE; mul_raw = 1'b1;
      end
      OP_SPD_INT:   begin mul_a = A_W'(err);       mul_b = K_DT5;                  end
      OP_SPD_P:     begin mul_a = A_W'(err);       mul_b = gain[REG_SPEED_KP];     end
      OP_SPD_I:     begin mul_a = sint;            mul_b = gain[REG_SPEED_KI];     end
      OP_ANG_P:     begin mul_a = A_W'(ang_err);   mul_b = gain[REG_ANGLE_KP];     end
      OP_ANG_D:     begin mul_a = A_W'(rate_r) <<< 8; mul_b = gain[REG_ANGLE_KD];  end
      OP_ROT_DIFF:  begin
        mul_a = A_W'(diff_lr); mul_b = K_DEG_PER_PULSE; mul_raw = 1'b1;
      end
      OP_ROT_INT:   begin mul_a = A_W'(err);       mul_b = K_DT;                   end
      OP_ROT_P:     begin mul_a = A_W'(err);       mul_b = gain[REG_ROTATE_KP];    end
      OP_ROT_I:     begin mul_a = rint;            mul_b = gain[REG_ROTATE_KI];    end
      default:      begin mul_a = '0;              mul_b = '0;                     end
    endcase
  end

  cbpid_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start),
    .raw   (mul_raw),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        gain[i] <= gain_reset(CFG_IDX_W'(i));
      end
    end else if (cfg_we) begin
      gain[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= left_count;
      right_r <= right_count;
      tilt_r  <= tilt;
      rate_r  <= tilt_rate;
      pgoal_r <= position_goal;
      hgoal_r <= heading_goal;
    end
    if (cmd.out_load) begin
      pwm_left     <= to_pwm(ang_sum - rot_sum);
      pwm_right    <= to_pwm(ang_sum + rot_sum);
      drive_enable <= (tilt_r < TILT_LIM) && (tilt_r > -TILT_LIM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err       <= '0;
      pos_eprev <= '0;
      mprev     <= '0;
      pos_hold  <= '0;
      spd_hold  <= '0;
      pint      <= '0;
      sint      <= '0;
      rint      <= '0;
      sum       <= '0;
      ang_sum   <= '0;
      rot_sum   <= '0;
    end else if (cmd.wb) begin
      unique case (cmd.op)
        OP_POS_DIST:  err <= sat32(SUM_W'(pgoal_r) - rx);
        OP_POS_INT:   pint <= A_W'(clamp_s(SUM_W'(pint) + rx, LIM_PROD));
        OP_POS_P:     sum <= rx;
        OP_POS_I:     sum <= sum + rx;
        OP_POS_D: begin
          pos_hold  <= 32'(clamp_s(sum + rx, LIM_POS));
          pos_eprev <= err;
        end
        OP_SPD_SCALE: begin
          err   <= sat32(rx - ((SUM_W'(mean) - SUM_W'(mprev)) <<< 16));
          mprev <= mean;
        end
        OP_SPD_INT:   sint <= A_W'(clamp_s(SUM_W'(sint) + rx, LIM_PROD));
        OP_SPD_P:     sum <= rx;
        OP_SPD_I:     spd_hold <= 32'(clamp_s(sum + rx, LIM_SPD));
        OP_ANG_P:     ang_sum <= rx;
        OP_ANG_D:     ang_sum <= ang_sum + rx;
        OP_ROT_DIFF:  err <= sat32(SUM_W'(hgoal_r) - rx);
        OP_ROT_INT:   rint <= A_W'(clamp_s(SUM_W'(rint) + rx, LIM_PROD));
        OP_ROT_P:     rot_sum <= rx;
        OP_ROT_I:     rot_sum <= rot_sum + rx;
        default:      sum <= sum;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cbpid_ctrl.sv =====
// Controller: request handshakes, tick phase and the sequence of multiply steps.
`timescale 1ns / 1ps
`default_nettype none
module cbpid_ctrl #(
  parameter int DECIMATION = cbpid_pkg::DECIMATION_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output cbpid_pkg::cmd_t cmd,
  input  cbpid_pkg::sts_t sts
);
  import cbpid_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ISSUE  = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]      state, state_next;
  logic [OP_W-1:0] op, op_next;
  logic [2:0]      phase, phase_next, phase_inc;
  logic            run;
  logic            accept;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign phase_inc = phase + 3'd1;
  assign run       = (phase_inc >= 3'(DECIMATION));

  always_comb begin
    state_next   = state;
    op_next      = op;
    phase_next   = phase;
    cmd.load     = 1'b0;
    cmd.start    = 1'b0;
    cmd.wb       = 1'b0;
    cmd.out_load = 1'b0;
    cmd.op       = op;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          phase_next = run ? 3'd0 : phase_inc;
          op_next    = run ? OP_POS_DIST : OP_ANG_P;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (sts.mul_done) begin
          cmd.wb = 1'b1;
          if (op == OP_ROT_I) begin
            state_next = S_FINISH;
          end else begin
            op_next    = op + OP_W'(1);
            state_next = S_ISSUE;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_POS_DIST;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      phase     <= phase_next;
      out_valid <= cmd.out_load || (out_valid && !out_ready);
    end
  end

  a_start_single: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !cmd.start)
    else $error("multiply started on two cycles in a row");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |-> (state == S_WAIT))
    else $error("multiply result arrived outside the wait state");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase < 3'(DECIMATION))
    else $error("tick phase out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/cascaded_balance_pid_core.sv =====
// Top level of the cascaded PID balance controller for a two-wheel robot.
`timescale 1ns / 1ps
`default_nettype none
// One request carries one control tick and yields one drive result. All products
// go through a single shared 24x32 multiplier. A plain tick runs the angle and
// rotation loops, six products; every DECIMATION-th tick also runs the position and
// speed loops, fifteen products. One tick is worked at a time; the result sits in an
// output register, so the next request is taken while it waits. The user must write
// gains through cfg_we, cfg_index and cfg_data only while the block is idle; the
// block itself does not enforce this.
module cascaded_balance_pid_core #(
  parameter int DECIMATION = cbpid_pkg::DECIMATION_DEF,
  parameter int PWM_LIMIT  = cbpid_pkg::PWM_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  cbpid_in_if.sink                        in_ch,
  cbpid_out_if.source                     out_ch,
  input  logic                            cfg_we,
  input  logic [cbpid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbpid_pkg::GAIN_W-1:0]    cfg_data
);
  import cbpid_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cbpid_ctrl #(
    .DECIMATION (DECIMATION)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cbpid_datapath #(
    .PWM_LIMIT (PWM_LIMIT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .left_count    (in_ch.left_count),
    .right_count   (in_ch.right_count),
    .tilt          (in_ch.tilt),
    .tilt_rate     (in_ch.tilt_rate),
    .position_goal (in_ch.position_goal),
    .heading_goal  (in_ch.heading_goal),
    .pwm_left      (out_ch.pwm_left),
    .pwm_right     (out_ch.pwm_right),
    .drive_enable  (out_ch.drive_enable)
  );

endmodule
`default_nettype wire
